[hdl/sort_by_rank_transform_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef SORT_BY_RANK_TRANSFORM_CORE_MACROS_SVH
`define SORT_BY_RANK_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication: when a holds, b holds.
`define RNKX_ASSERT_IMP(lbl, clk, dis, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) else $error(msg);

// Next-cycle implication: when a holds, b must hold in the cycle after.
`define RNKX_ASSERT_NXT(lbl, clk, dis, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) else $error(msg);

`endif

[hdl/rnkx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnkx_pkg
// Shared constants and types of the rank transform core.
// ----------------------------------------------------------------------------
package rnkx_pkg;

    localparam int ALPHABET = 256;
    localparam int POS_BITS = 24;
    localparam int RANK_W   = $clog2(ALPHABET);

    localparam logic [1:0] MODE_FRONT = 2'd0;
    localparam logic [1:0] MODE_AVG   = 2'd1;
    localparam logic [1:0] MODE_TIME  = 2'd2;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_DIR  = 1'b1;

    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_INV = 1'b1;

    // one rank slot: symbol held there, its key and its last position
    typedef struct packed {
        logic [RANK_W-1:0]   sym;
        logic [POS_BITS-1:0] key;
        logic [POS_BITS-1:0] last;
    } cell_t;

endpackage

[hdl/sort_by_rank_transform_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_by_rank_transform_core
// Byte rank transform (move-to-front, rank average, timestamp keys).
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request per byte: tdata = symbol (or rank when
//   inverse), tuser = block_start. m_ channel returns one byte per request:
//   the rank (forward) or the symbol (inverse).
//   cfg_we/cfg_index/cfg_wdata write transform_mode (0) and direction (1);
//   write only while the core is idle.
//   After accept, each request goes in order through a lookup in the row of
//   rank cells, a key compare in every cell, then one shift of the row that
//   moves the symbol up, and its result is registered into m_tdata. A new
//   request is taken only after the last one is back in idle; the next
//   request is accepted while a finished result waits in the output register.
//   Reset (aresetn low, synchronous) restores the identity ranking, clears
//   keys, positions and the control registers. block_start does the same for the
//   tables and position at accept time. If the receiver stalls, the result
//   holds in m_tdata and the core stops after finishing the next request.
// ----------------------------------------------------------------------------
module sort_by_rank_transform_core import rnkx_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tuser,   // [0] block_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] value
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [1:0] cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIND = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_MOVE = 2'd3;

    logic [1:0]          st_reg, st_next;
    logic [1:0]          mode_reg;
    logic                dir_reg;
    logic [RANK_W-1:0]   sym_reg;
    logic [RANK_W-1:0]   rank_reg;
    logic [RANK_W-1:0]   csym_reg;
    logic [POS_BITS-1:0] key_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic [7:0]          val_reg;
    logic                mvalid_reg;
    logic                pend_reg;
    logic [ALPHABET-1:0] gt_reg;

    cell_t               cell_q [ALPHABET];
    logic [ALPHABET-1:0] match_v, gt_v, shift_v, load_v;
    cell_t               load_data;
    logic                accept, clr, out_free;
    logic [8:0]          in_ext;
    logic [RANK_W-1:0]   in_clamp, fwd_rank, rank_sel, csym, new_rank;
    cell_t               sel;
    logic [POS_BITS:0]   avg_sum;
    logic [POS_BITS-1:0] key_c;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (st_reg == ST_IDLE) && !pend_reg;
    assign clr      = !aresetn || (accept && s_tuser);
    assign out_free = !mvalid_reg || m_tready;

    // clamp input byte to the alphabet
    assign in_ext   = {1'b0, s_tdata};
    assign in_clamp = (in_ext >= 9'(ALPHABET)) ? RANK_W'(ALPHABET - 1) : RANK_W'(s_tdata);

    // row of rank cells
    assign load_data = '{sym: csym_reg, key: key_reg, last: pos_reg};
    for (genvar j = 0; j < ALPHABET; j++) begin : g_cell
        rnkx_cell u_cell (
            .aclk      (aclk),
            .clear     (clr),
            .init_sym  (RANK_W'(j)),
            .shift_en  (shift_v[j]),
            .load_en   (load_v[j]),
            .upper     (cell_q[(j == 0) ? 0 : j - 1]),
            .load_data (load_data),
            .match_sym (sym_reg),
            .cmp_key   (key_reg),
            .data      (cell_q[j]),
            .match     (match_v[j]),
            .gt        (gt_v[j])
        );
    end

    // lookup: rank of the symbol (forward) or the slot itself (inverse)
    always_comb begin
        fwd_rank = '0;
        for (int j = 0; j < ALPHABET; j++) begin
            if (match_v[j]) fwd_rank = fwd_rank | RANK_W'(j);
        end
    end
    assign rank_sel = (dir_reg == DIR_FWD) ? fwd_rank : sym_reg;
    assign sel      = cell_q[rank_sel];
    assign csym     = (dir_reg == DIR_FWD) ? sym_reg : sel.sym;

    // key of the symbol
    assign avg_sum = {1'b0, pos_reg} + {1'b0, sel.last};
    always_comb begin
        case (mode_reg)
            MODE_AVG:  key_c = avg_sum[POS_BITS:1];
            MODE_TIME: key_c = sel.last;
            default:   key_c = pos_reg;
        endcase
    end

    // new rank: one below the nearest higher slot with a larger key
    always_comb begin
        new_rank = '0;
        for (int j = 0; j < ALPHABET - 1; j++) begin
            if (gt_reg[j]) new_rank = RANK_W'(j + 1);
        end
    end

    // move enables
    always_comb begin
        for (int j = 0; j < ALPHABET; j++) begin
            shift_v[j] = (st_reg == ST_MOVE) && (RANK_W'(j) > new_rank)
                         && (RANK_W'(j) <= rank_reg);
            load_v[j]  = (st_reg == ST_MOVE) && (RANK_W'(j) == new_rank);
        end
    end

    // sequencer
    always_comb begin
        case (st_reg)
            ST_IDLE: st_next = accept ? ST_FIND : ST_IDLE;
            ST_FIND: st_next = ST_CMP;
            ST_CMP:  st_next = ST_MOVE;
            ST_MOVE: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            mode_reg   <= MODE_FRONT;
            dir_reg    <= DIR_FWD;
            mvalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
            pos_reg    <= '0;
        end else begin
            st_reg <= st_next;
            if (cfg_we && cfg_index == REG_MODE) mode_reg <= cfg_wdata;
            if (cfg_we && cfg_index == REG_DIR)  dir_reg  <= cfg_wdata[0];
            if (accept && s_tuser) begin
                pos_reg <= '0;
            end else if (st_reg == ST_MOVE && pos_reg != {POS_BITS{1'b1}}) begin
                pos_reg <= pos_reg + 1'b1;
            end
            // result hand-off to the output register
            if ((st_reg == ST_MOVE || pend_reg) && out_free) begin
                mvalid_reg <= 1'b1;
                pend_reg   <= 1'b0;
            end else begin
                if (m_tready) mvalid_reg <= 1'b0;
                if (st_reg == ST_MOVE) pend_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) sym_reg <= in_clamp;
        if (st_reg == ST_FIND) begin
            rank_reg <= rank_sel;
            csym_reg <= csym;
            key_reg  <= key_c;
        end
        if (st_reg == ST_CMP) begin
            for (int j = 0; j < ALPHABET; j++) begin
                gt_reg[j] <= gt_v[j] && (RANK_W'(j) < rank_reg);
            end
        end
    end

    logic [7:0] val_c;
    assign val_c = (dir_reg == DIR_FWD) ? 8'(rank_reg) : 8'(csym_reg);
    always_ff @(posedge aclk) begin
        if ((st_reg == ST_MOVE || pend_reg) && out_free) begin
            m_tdata <= pend_reg ? val_reg : val_c;
        end
        if (st_reg == ST_MOVE) val_reg <= val_c;
    end

    assign m_tvalid = mvalid_reg;

endmodule

[hdl/rnkx_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnkx_cell
// One slot of the ranking: holds a symbol with its key and last position,
// compares against the search symbol and key, and takes its upper neighbor.
// ----------------------------------------------------------------------------
module rnkx_cell import rnkx_pkg::*; (
    input  logic              aclk,
    input  logic              clear,
    input  logic [RANK_W-1:0] init_sym,
    input  logic              shift_en,
    input  logic              load_en,
    input  cell_t             upper,
    input  cell_t             load_data,
    input  logic [RANK_W-1:0] match_sym,
    input  logic [POS_BITS-1:0] cmp_key,
    output cell_t             data,
    output logic              match,
    output logic              gt
);

    cell_t data_reg;

    // slot update: clear to identity, load new symbol, or move down one rank
    always_ff @(posedge aclk) begin
        if (clear) begin
            data_reg.sym  <= init_sym;
            data_reg.key  <= '0;
            data_reg.last <= '0;
        end else if (load_en) begin
            data_reg <= load_data;
        end else if (shift_en) begin
            data_reg <= upper;
        end
    end

    assign data  = data_reg;
    assign match = (data_reg.sym == match_sym);
    assign gt    = (data_reg.key > cmp_key);

endmodule

[hdl/rnkx_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnkx_checker
// Port-level checks of the rank transform core, bound to the top level.
// ----------------------------------------------------------------------------
`include "sort_by_rank_transform_core_macros.svh"

module rnkx_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // stalled result holds
    `RNKX_ASSERT_NXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed under stall")

    // one request at a time: busy right after accept
    `RNKX_ASSERT_NXT(a_busy, aclk, !aresetn, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // no result right after reset
    `RNKX_ASSERT_NXT(a_reset, aclk, 1'b0, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind sort_by_rank_transform_core rnkx_checker u_rnkx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte requests through the rank transform core in every key mode and
// both directions, predicts each output byte and checks it in order.
// ----------------------------------------------------------------------------

// Rank list model and queue of expected output bytes.
class rank_scoreboard;
    logic [23:0] last_pos [256];
    logic [23:0] key_of [256];
    logic [7:0]  sym_at_rank [256];
    logic [7:0]  rank_of_sym [256];
    logic [23:0] pos;
    logic [1:0]  mode;
    logic        dir;
    logic [7:0]  expected_bytes [$];
    int          mismatches;

    function void clear_tables();
        for (int k = 0; k < 256; k++) begin
            last_pos[k] = '0;
            key_of[k] = '0;
            sym_at_rank[k] = k[7:0];
            rank_of_sym[k] = k[7:0];
        end
        pos = '0;
    endfunction

    function void note_request(logic [7:0] data, logic start);
        logic [7:0] c;
        logic [7:0] s;
        logic [23:0] k;
        int r;
        if (start) clear_tables();
        if (dir == rnkx_pkg::DIR_FWD) begin
            c = data;
            r = rank_of_sym[c];
            expected_bytes.push_back(r[7:0]);
        end else begin
            r = data;
            c = sym_at_rank[r];
            expected_bytes.push_back(c);
        end
        if (mode == rnkx_pkg::MODE_AVG) k = 24'(({1'b0, pos} + {1'b0, last_pos[c]}) >> 1);
        else if (mode == rnkx_pkg::MODE_TIME) k = last_pos[c];
        else k = pos;
        last_pos[c] = pos;
        key_of[c] = k;
        // bubble the symbol up past neighbors whose key is not greater
        while (r > 0) begin
            s = sym_at_rank[r-1];
            if (key_of[s] > k) break;
            sym_at_rank[r] = s;
            rank_of_sym[s] = r[7:0];
            r--;
        end
        sym_at_rank[r] = c;
        rank_of_sym[c] = r[7:0];
        if (pos != 24'hFFFFFF) pos++;
    endfunction

    function void check_result(logic [7:0] got);
        logic [7:0] want;
        if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d", got);
            return;
        end
        want = expected_bytes.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("value mismatch: expected %0d actual %0d", want, got);
        end
    endfunction
endclass

module testbench;
    import rnkx_pkg::*;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic       s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [1:0] cfg_wdata = '0;

    rank_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_off = 1'b0;
    bit  stall_busy = 1'b0;

    sort_by_rank_transform_core DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Timeout guard.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check accepted bytes, stall on its own pattern.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (hold_off) m_tready <= 1'b0;
        else if (stall_busy) m_tready <= ($urandom_range(0, 3) == 0);
        else m_tready <= ($urandom_range(0, 7) != 0);
    end

    initial begin
        forever begin
            repeat ($urandom_range(20, 200)) @(posedge aclk);
            stall_busy = ~stall_busy;
        end
    end

    task automatic write_reg(logic idx, logic [1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_MODE) sb.mode = val;
        else sb.dir = val[0];
        @(posedge aclk);
    endtask

    // Offer one request and hold it until accepted.
    task automatic send_byte(logic [7:0] data, logic start);
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(data, start);
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    initial begin
        int burst;
        logic [7:0] d;
        sb.mismatches = 0;
        sb.mode = MODE_FRONT;
        sb.dir = DIR_FWD;
        sb.clear_tables();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, repeats, every mode incl. the unused one, both directions.
        for (int m = 0; m < 4; m++) begin
            write_reg(REG_MODE, m[1:0]);
            for (int dr = 0; dr < 2; dr++) begin
                write_reg(REG_DIR, {1'b0, dr[0]});
                send_byte(8'd255, 1'b1);
                send_byte(8'd0, 1'b0);
                send_byte(8'd255, 1'b0);
                drain();
            end
        end
        // direction change mid-block
        write_reg(REG_MODE, MODE_AVG);
        write_reg(REG_DIR, {1'b0, DIR_FWD});
        send_byte(8'd7, 1'b1);
        send_byte(8'd9, 1'b0);
        drain();
        write_reg(REG_DIR, {1'b0, DIR_INV});
        send_byte(8'd1, 1'b0);
        drain();

        // Random phases across settings; small alphabet subsets make repeats likely.
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_MODE, 2'($urandom_range(0, 3)));
            write_reg(REG_DIR, 2'($urandom_range(0, 1)));
            // long receiver hold-off, timed in cycles while the sender keeps going
            if (ph == 3) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 1)) d = 8'($urandom_range(0, 15));
                else d = 8'($urandom);
                if (i < 2 || $urandom_range(0, 60) == 0) d = (i == 0) ? 8'd0 : d;
                send_byte(d, (i == 0) || ($urandom_range(0, 50) == 0));
                burst--;
                if (burst <= 0) begin
                    burst = $urandom_range(1, 20);
                    gap();
                end
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
